FILE: rtl/tt_pkg.sv
// Package for the thermal throttle block: field widths, register indexes
// and the brightness caps and TX power codes that go with each level.
// Has no dependencies.
`default_nettype none

package tt_pkg;

    localparam int TEMP_W   = 12;
    localparam int HYS_W    = 10;
    localparam int FREQ_W   = 9;
    localparam int LEVEL_W  = 2;
    localparam int TX_W     = 2;
    localparam int CAP_W    = 8;
    localparam int IVAL_W   = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_SOFT_THR  = 3'd0;
    localparam t_cfg_idx REG_HARD_THR  = 3'd1;
    localparam t_cfg_idx REG_CRIT_THR  = 3'd2;
    localparam t_cfg_idx REG_HYSTERESIS = 3'd3;
    localparam t_cfg_idx REG_MHZ_NORMAL = 3'd4;
    localparam t_cfg_idx REG_MHZ_SOFT  = 3'd5;
    localparam t_cfg_idx REG_MHZ_HARD  = 3'd6;
    localparam t_cfg_idx REG_COOL_IVAL = 3'd7;

    localparam logic [CAP_W-1:0] CAP_NORMAL = 8'd255;
    localparam logic [CAP_W-1:0] CAP_SOFT   = 8'd16;
    localparam logic [CAP_W-1:0] CAP_HARD   = 8'd2;
    localparam logic [CAP_W-1:0] CAP_CRIT   = 8'd0;

    localparam logic [TX_W-1:0] TX_15DBM  = 2'd0;
    localparam logic [TX_W-1:0] TX_11DBM  = 2'd1;
    localparam logic [TX_W-1:0] TX_8P5DBM = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/tt_in_if.sv
// Request channel carrying one temperature sample.
// Depends on tt_pkg for the field width.
`default_nettype none

interface tt_in_if
    import tt_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temperature;

    modport source (output valid, output temperature, input ready);
    modport sink   (input valid, input temperature, output ready);
endinterface

`default_nettype wire

FILE: rtl/tt_out_if.sv
// Request channel carrying one change-of-level result.
// Depends on tt_pkg for the field widths.
`default_nettype none

interface tt_out_if
    import tt_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level;
    logic [FREQ_W-1:0]  cpu_freq_mhz;
    logic [TX_W-1:0]    tx_power_code;
    logic               power_save_max;
    logic [CAP_W-1:0]   brightness_cap;
    logic               sleep_request;
    logic [IVAL_W-1:0]  sleep_interval_ms;

    modport source (output valid, output level, output cpu_freq_mhz, output tx_power_code,
                    output power_save_max, output brightness_cap, output sleep_request,
                    output sleep_interval_ms, input ready);
    modport sink   (input valid, input level, input cpu_freq_mhz, input tx_power_code,
                    input power_save_max, input brightness_cap, input sleep_request,
                    input sleep_interval_ms, output ready);
endinterface

`default_nettype wire

FILE: rtl/thermal_throttle_hysteresis_fsm.sv
// Top level of the thermal throttle: sample register, level logic with
// hysteresis, and result register. Depends on tt_pkg, tt_in_if and tt_out_if.
//
// Each temperature request is captured in an input register and, in the next
// cycle, compared against the thresholds and the current level; a result
// request is issued only when the level changes. One sample is taken every
// cycle while not stalled; the result is registered after the input register.
// The single result register holds off new samples only while a result is
// waiting and another change is due. Critical is left only by reset.
`default_nettype none

module thermal_throttle_hysteresis_fsm
    import tt_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    tt_in_if.sink                  i_sample,
    tt_out_if.source               o_result,
    input  wire                    i_cfg_we,
    input  wire [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [CFG_DATA_W-1:0]   i_cfg_data
);

    typedef enum logic [LEVEL_W-1:0] {
        LVL_NORMAL   = 2'd0,
        LVL_SOFT     = 2'd1,
        LVL_HARD     = 2'd2,
        LVL_CRITICAL = 2'd3
    } t_level;

    logic signed [TEMP_W-1:0] r_soft_thr;
    logic signed [TEMP_W-1:0] r_hard_thr;
    logic signed [TEMP_W-1:0] r_crit_thr;
    logic [HYS_W-1:0]         r_hys;
    logic [FREQ_W-1:0]        r_mhz_normal;
    logic [FREQ_W-1:0]        r_mhz_soft;
    logic [FREQ_W-1:0]        r_mhz_hard;
    logic [IVAL_W-1:0]        r_cool_ival;

    t_level                   r_level;
    t_level                   n_level;
    logic                     r_in_valid;
    logic signed [TEMP_W-1:0] r_temp;
    logic                     r_out_valid;

    logic signed [TEMP_W:0]   temp_x;
    logic signed [TEMP_W:0]   soft_down;
    logic signed [TEMP_W:0]   hard_down;
    logic                     ge_crit;
    logic                     ge_hard;
    logic                     ge_soft;
    logic                     below_soft;
    logic                     below_hard;
    logic                     change;
    logic                     advance;

    assign temp_x    = {r_temp[TEMP_W-1], r_temp};
    assign soft_down = {r_soft_thr[TEMP_W-1], r_soft_thr}
                       - $signed({{(TEMP_W+1-HYS_W){1'b0}}, r_hys});
    assign hard_down = {r_hard_thr[TEMP_W-1], r_hard_thr}
                       - $signed({{(TEMP_W+1-HYS_W){1'b0}}, r_hys});

    assign ge_crit    = r_temp >= r_crit_thr;
    assign ge_hard    = r_temp >= r_hard_thr;
    assign ge_soft    = r_temp >= r_soft_thr;
    assign below_soft = temp_x < soft_down;
    assign below_hard = temp_x < hard_down;

    always_comb begin
        n_level = r_level;
        unique case (r_level)
            LVL_NORMAL: begin
                if (ge_crit) n_level = LVL_CRITICAL;
                else if (ge_hard) n_level = LVL_HARD;
                else if (ge_soft) n_level = LVL_SOFT;
            end
            LVL_SOFT: begin
                if (ge_crit) n_level = LVL_CRITICAL;
                else if (ge_hard) n_level = LVL_HARD;
                else if (below_soft) n_level = LVL_NORMAL;
            end
            LVL_HARD: begin
                if (ge_crit) n_level = LVL_CRITICAL;
                else if (below_hard) n_level = below_soft ? LVL_NORMAL : LVL_SOFT;
            end
            default: n_level = LVL_CRITICAL;
        endcase
    end

    assign change  = r_in_valid && (n_level != r_level);
    assign advance = r_in_valid && (!change || !r_out_valid || o_result.ready);

    assign i_sample.ready = !r_in_valid || advance;
    assign o_result.valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_soft_thr    <= 12'sd560;
            r_hard_thr    <= 12'sd640;
            r_crit_thr    <= 12'sd720;
            r_hys         <= 10'd40;
            r_mhz_normal  <= 9'd240;
            r_mhz_soft    <= 9'd160;
            r_mhz_hard    <= 9'd80;
            r_cool_ival   <= 24'd60000;
            r_level       <= LVL_NORMAL;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_SOFT_THR:    r_soft_thr    <= i_cfg_data[TEMP_W-1:0];
                    REG_HARD_THR:    r_hard_thr    <= i_cfg_data[TEMP_W-1:0];
                    REG_CRIT_THR:    r_crit_thr    <= i_cfg_data[TEMP_W-1:0];
                    REG_HYSTERESIS:  r_hys         <= i_cfg_data[HYS_W-1:0];
                    REG_MHZ_NORMAL:  r_mhz_normal  <= i_cfg_data[FREQ_W-1:0];
                    REG_MHZ_SOFT:    r_mhz_soft    <= i_cfg_data[FREQ_W-1:0];
                    REG_MHZ_HARD:    r_mhz_hard    <= i_cfg_data[FREQ_W-1:0];
                    REG_COOL_IVAL:   r_cool_ival   <= i_cfg_data[IVAL_W-1:0];
                    default: ;
                endcase
            end

            if (i_sample.valid && i_sample.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance && change) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            if (advance) begin
                r_level <= n_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_temp <= i_sample.temperature;
        end
        if (advance && change) begin
            o_result.level             <= n_level;
            o_result.power_save_max    <= 1'b0;
            o_result.sleep_request     <= 1'b0;
            o_result.sleep_interval_ms <= '0;
            unique case (n_level)
                LVL_NORMAL: begin
                    o_result.cpu_freq_mhz   <= r_mhz_normal;
                    o_result.tx_power_code  <= TX_15DBM;
                    o_result.brightness_cap <= CAP_NORMAL;
                end
                LVL_SOFT: begin
                    o_result.cpu_freq_mhz   <= r_mhz_soft;
                    o_result.tx_power_code  <= TX_11DBM;
                    o_result.brightness_cap <= CAP_SOFT;
                end
                LVL_HARD: begin
                    o_result.cpu_freq_mhz   <= r_mhz_hard;
                    o_result.tx_power_code  <= TX_8P5DBM;
                    o_result.brightness_cap <= CAP_HARD;
                    o_result.power_save_max <= 1'b1;
                end
                default: begin
                    o_result.cpu_freq_mhz      <= r_mhz_hard;
                    o_result.tx_power_code     <= TX_8P5DBM;
                    o_result.brightness_cap    <= CAP_CRIT;
                    o_result.sleep_request     <= 1'b1;
                    o_result.sleep_interval_ms <= r_cool_ival;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: tb/thermal_throttle_hysteresis_fsm_test.sv
// Self-checking testbench for thermal_throttle_hysteresis_fsm: directed and random
// temperature requests under varied flow control, checked against an in-bench level predictor.
// Depends on tt_pkg, tt_in_if, tt_out_if and the block itself.
module thermal_throttle_hysteresis_fsm_test;
    import tt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_SAMPLES = 230;

    typedef enum logic [LEVEL_W-1:0] {
        LVL_NORMAL, LVL_SOFT, LVL_HARD, LVL_CRITICAL
    } t_level;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [FREQ_W-1:0]  cpu_freq_mhz;
        logic [TX_W-1:0]    tx_power_code;
        logic               power_save_max;
        logic [CAP_W-1:0]   brightness_cap;
        logic               sleep_request;
        logic [IVAL_W-1:0]  sleep_interval_ms;
    } t_level_change;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tt_in_if  sample_if();
    tt_out_if result_if();

    thermal_throttle_hysteresis_fsm i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (sample_if),
        .o_result    (result_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Predictor copy of the registers and the thermal level, at reset values.
    logic signed [TEMP_W-1:0] soft_thr  = 12'sd560;
    logic signed [TEMP_W-1:0] hard_thr  = 12'sd640;
    logic signed [TEMP_W-1:0] crit_thr  = 12'sd720;
    logic [HYS_W-1:0]         hys_reg   = 10'd40;
    logic [FREQ_W-1:0]        mhz_normal  = 9'd240;
    logic [FREQ_W-1:0]        mhz_soft    = 9'd160;
    logic [FREQ_W-1:0]        mhz_hard    = 9'd80;
    logic [IVAL_W-1:0]        cool_ival   = 24'd60000;
    t_level                   level_now = LVL_NORMAL;

    t_level_change pending_changes[$];
    t_level_change seen_change;
    t_level_change want_change;

    int gap_pct = 0;
    int stall_pct = 0;
    int walk_temp = 0;
    int samples_sent = 0;
    int changes_seen = 0;
    int settings_loaded = 0;
    int mismatches = 0;
    int cycle_count = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_level next_level(t_level cur, int t);
        int soft_i;
        int hard_i;
        int crit_i;
        int hys_i;
        soft_i = int'(soft_thr);
        hard_i = int'(hard_thr);
        crit_i = int'(crit_thr);
        hys_i  = int'(hys_reg);
        case (cur)
            LVL_NORMAL: begin
                if (t >= crit_i) return LVL_CRITICAL;
                if (t >= hard_i) return LVL_HARD;
                if (t >= soft_i) return LVL_SOFT;
                return LVL_NORMAL;
            end
            LVL_SOFT: begin
                if (t >= crit_i) return LVL_CRITICAL;
                if (t >= hard_i) return LVL_HARD;
                if (t < soft_i - hys_i) return LVL_NORMAL;
                return LVL_SOFT;
            end
            LVL_HARD: begin
                if (t >= crit_i) return LVL_CRITICAL;
                if (t < hard_i - hys_i) begin
                    if (t < soft_i - hys_i) return LVL_NORMAL;
                    return LVL_SOFT;
                end
                return LVL_HARD;
            end
            default: return LVL_CRITICAL;
        endcase
    endfunction

    function automatic t_level_change level_change_for(t_level lvl);
        t_level_change c;
        c = '0;
        c.level = lvl;
        case (lvl)
            LVL_NORMAL: begin
                c.cpu_freq_mhz   = mhz_normal;
                c.tx_power_code  = TX_15DBM;
                c.brightness_cap = CAP_NORMAL;
            end
            LVL_SOFT: begin
                c.cpu_freq_mhz   = mhz_soft;
                c.tx_power_code  = TX_11DBM;
                c.brightness_cap = CAP_SOFT;
            end
            LVL_HARD: begin
                c.cpu_freq_mhz   = mhz_hard;
                c.tx_power_code  = TX_8P5DBM;
                c.brightness_cap = CAP_HARD;
                c.power_save_max = 1'b1;
            end
            default: begin
                c.cpu_freq_mhz      = mhz_hard;
                c.tx_power_code     = TX_8P5DBM;
                c.brightness_cap    = CAP_CRIT;
                c.sleep_request     = 1'b1;
                c.sleep_interval_ms = cool_ival;
            end
        endcase
        return c;
    endfunction

    function automatic void apply_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_SOFT_THR:    soft_thr    = data[TEMP_W-1:0];
            REG_HARD_THR:    hard_thr    = data[TEMP_W-1:0];
            REG_CRIT_THR:    crit_thr    = data[TEMP_W-1:0];
            REG_HYSTERESIS:  hys_reg     = data[HYS_W-1:0];
            REG_MHZ_NORMAL:  mhz_normal  = data[FREQ_W-1:0];
            REG_MHZ_SOFT:    mhz_soft    = data[FREQ_W-1:0];
            REG_MHZ_HARD:    mhz_hard    = data[FREQ_W-1:0];
            default:         cool_ival   = data[IVAL_W-1:0];
        endcase
    endfunction

    function automatic string show_change(t_level_change c);
        return $sformatf("level=%0d freq=%0d tx=%0d ps=%0b cap=%0d sleep=%0b ival=%0d",
                         c.level, c.cpu_freq_mhz, c.tx_power_code, c.power_save_max,
                         c.brightness_cap, c.sleep_request, c.sleep_interval_ms);
    endfunction

    // Mostly samples near the thresholds and their step-down points, or a random walk,
    // always kept below the critical threshold.
    function automatic int pick_temperature();
        int lo;
        int hi;
        int t;
        int step;
        lo = -2048;
        hi = int'(crit_thr) - 1;
        step = int'(hys_reg) / 4 + 8;
        case ($urandom_range(9))
            0, 1: t = lo + int'($urandom_range(hi - lo));
            2: t = int'(soft_thr) + int'($urandom_range(4)) - 2;
            3: t = int'(hard_thr) + int'($urandom_range(4)) - 2;
            4: t = int'(soft_thr) - int'(hys_reg) + int'($urandom_range(4)) - 2;
            5: t = int'(hard_thr) - int'(hys_reg) + int'($urandom_range(4)) - 2;
            default: t = walk_temp + int'($urandom_range(2 * step)) - step;
        endcase
        if (t < lo) t = lo;
        if (t > hi) t = hi;
        walk_temp = t;
        return t;
    endfunction

    task automatic write_settings(input int soft_val, input int hard_val, input int crit,
                                  input int hys, input int fn, input int fs, input int fh,
                                  input int cool);
        logic [CFG_DATA_W-1:0] plan [8];
        plan[REG_SOFT_THR]    = CFG_DATA_W'(soft_val);
        plan[REG_HARD_THR]    = CFG_DATA_W'(hard_val);
        plan[REG_CRIT_THR]    = CFG_DATA_W'(crit);
        plan[REG_HYSTERESIS]  = CFG_DATA_W'(hys);
        plan[REG_MHZ_NORMAL]  = CFG_DATA_W'(fn);
        plan[REG_MHZ_SOFT]    = CFG_DATA_W'(fs);
        plan[REG_MHZ_HARD]    = CFG_DATA_W'(fh);
        plan[REG_COOL_IVAL]   = CFG_DATA_W'(cool);
        for (int i = REG_SOFT_THR; i <= REG_COOL_IVAL; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= t_cfg_idx'(i);
            cfg_data  <= plan[i];
            @(posedge i_clk);
            apply_reg(t_cfg_idx'(i), plan[i]);
        end
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    task automatic send_temperature(input int t);
        t_level nxt;
        if ($urandom_range(99) < gap_pct) begin
            sample_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < gap_pct);
        end
        sample_if.valid       <= 1'b1;
        sample_if.temperature <= TEMP_W'(t);
        do @(posedge i_clk); while (!sample_if.ready);
        samples_sent++;
        nxt = next_level(level_now, t);
        if (nxt != level_now) begin
            pending_changes.push_back(level_change_for(nxt));
            level_now = nxt;
        end
    endtask

    task automatic wait_idle();
        sample_if.valid <= 1'b0;
        while (pending_changes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_default_thresholds();
        int temps [10] = '{559, 560, 640, 601, 599, 520, 519, -2048, 700, 100};
        foreach (temps[i]) send_temperature(temps[i]);
        wait_idle();
    endtask

    // The soft step-down point falls outside the 12-bit range here, and one frequency is zero.
    task automatic test_extreme_registers();
        int temps [4] = '{-2048, 2046, 1023, 1022};
        write_settings(-2048, 2046, 2047, 1023, 0, 511, 1, 0);
        foreach (temps[i]) send_temperature(temps[i]);
        wait_idle();
    endtask

    task automatic test_unordered_thresholds();
        int temps [5] = '{400, 299, 300, 999, 600};
        write_settings(500, 300, 1000, 0, 511, 1, 0, 16777215);
        foreach (temps[i]) send_temperature(temps[i]);
        wait_idle();
    endtask

    task automatic test_random_hysteresis();
        int crit;
        int a;
        int b;
        int swap;
        int hys;
        int cool;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            crit = (phase == 0) ? 2047 : int'($urandom_range(2047, 256));
            a = int'($urandom_range(crit + 2047)) - 2048;
            b = int'($urandom_range(crit + 2047)) - 2048;
            if (a > b && $urandom_range(9) < 7) begin
                swap = a;
                a = b;
                b = swap;
            end
            case (phase)
                1: hys = 1023;
                2: hys = 0;
                default: hys = $urandom_range(1) ? int'($urandom_range(63))
                                                 : int'($urandom_range(1023));
            endcase
            case (phase)
                2: cool = 0;
                3: cool = 16777215;
                default: cool = int'($urandom_range(16777215));
            endcase
            write_settings(a, b, crit, hys, int'($urandom_range(511)),
                           int'($urandom_range(511)), int'($urandom_range(511)), cool);
            case (phase % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 74; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 74; end
                default: begin gap_pct = 19; stall_pct = 19; end
            endcase
            walk_temp = a;
            repeat (PHASE_SAMPLES) send_temperature(pick_temperature());
            wait_idle();
        end
        gap_pct = 0;
        stall_pct = 0;
    endtask

    // Critical is only left by reset, so it is entered once, at the end of the run.
    task automatic test_critical_latch();
        int temps [4] = '{2047, -2048, 0, 2047};
        write_settings(0, 100, -2048, 1023, 1, 511, 511, 16777215);
        gap_pct = 19;
        stall_pct = 19;
        foreach (temps[i]) send_temperature(temps[i]);
        wait_idle();
    endtask

    always @(posedge i_clk) begin
        result_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready) begin
            seen_change = '{result_if.level, result_if.cpu_freq_mhz, result_if.tx_power_code,
                            result_if.power_save_max, result_if.brightness_cap,
                            result_if.sleep_request, result_if.sleep_interval_ms};
            changes_seen++;
            if (pending_changes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: level change with none pending: %s",
                             show_change(seen_change));
            end else begin
                want_change = pending_changes.pop_front();
                if (seen_change !== want_change) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ERROR: level change mismatch");
                        $display("  expected %s", show_change(want_change));
                        $display("  actual   %s", show_change(seen_change));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles, %0d level changes pending",
                     cycle_count, pending_changes.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        i_rst_n               <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_index             <= REG_SOFT_THR;
        cfg_data              <= '0;
        sample_if.valid       <= 1'b0;
        sample_if.temperature <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_thresholds();
        test_extreme_registers();
        test_unordered_thresholds();
        test_random_hysteresis();
        test_critical_latch();

        $display("Sent %0d temperature samples across %0d register settings and four",
                 samples_sent, settings_loaded + 1);
        $display("flow-control mixes; checked %0d level changes, ending in the critical latch.",
                 changes_seen);
        if (mismatches == 0 && pending_changes.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/tt_pkg.sv
rtl/tt_in_if.sv
rtl/tt_out_if.sv
rtl/thermal_throttle_hysteresis_fsm.sv
tb/thermal_throttle_hysteresis_fsm_test.sv
